FILE: src/hsvg_pkg.sv
// hand shape vertex generator: shared types, constants and the trig divide
// no dependencies
package hsvg_pkg;

   localparam int FRAC_BITS  = 4;
   localparam int TRIG_SHIFT = 16;
   localparam int TRIG_SCALE = (1 << TRIG_SHIFT) - 1;

   // axial distances, half-widths, products and quotients
   localparam int AW = 15;
   localparam int HW = 8 + FRAC_BITS - 1;
   localparam int PW = 32;
   localparam int QW = 17;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HAND_STYLE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HAND_LENGTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL_LENGTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIDDLE_DISTANCE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_WIDTH      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_WIDTH    = 3'd5;

   // hand styles
   localparam logic [2:0] STYLE_DOT      = 3'd0;
   localparam logic [2:0] STYLE_TRIANGLE = 3'd1;
   localparam logic [2:0] STYLE_SQUARE   = 3'd2;
   localparam logic [2:0] STYLE_DAUPHINE = 3'd3;
   localparam logic [2:0] STYLE_SWORD    = 3'd4;
   localparam logic [2:0] STYLE_POMME    = 3'd5;
   localparam logic [2:0] STYLE_SPADE    = 3'd6;
   localparam logic [2:0] STYLE_ARROW    = 3'd7;

   typedef enum logic [2:0] {
      AX_B, AX_L, AX_M, AX_MID, AX_BACK, AX_APEX, AX_LM
   } axis_sel_type;

   typedef enum logic [1:0] {
      SD_NONE, SD_NEG, SD_POS
   } side_type;

   // one primitive of the sequence
   typedef struct packed {
      logic         is_circle;
      logic [1:0]   shape_index;
      logic [2:0]   vertex_index;
      axis_sel_type axis;
      side_type     side;
      logic         half_second;
      logic         thin_second;
      logic         last;
   } prim_desc_type;

   // signed product / TRIG_SCALE, truncated toward zero (reciprocal plus correction)
   function automatic logic signed [QW-1:0] div_trig(input logic signed [PW-1:0] p);
      logic [PW-1:0]        n;
      logic [PW-1:0]        q;
      logic signed [PW+1:0] r;
      n = p[PW-1] ? PW'(-p) : PW'(p);
      q = PW'(({1'b0, n} + {1'b0, (n >> TRIG_SHIFT)} + 33'd1) >> TRIG_SHIFT);
      r = $signed({2'b00, n}) - $signed({2'b00, (q << TRIG_SHIFT)}) + $signed({2'b00, q});
      if (r < 0) begin
         q = q - PW'(1);
      end else if (r >= (PW+2)'(TRIG_SCALE)) begin
         q = q + PW'(1);
      end
      return p[PW-1] ? QW'(-q) : QW'(q);
   endfunction

endpackage

FILE: src/hsvg_if.sv
// hand shape vertex generator: channel interfaces for items, results and registers
// depends on hsvg_pkg
interface hsvg_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pivot_x;
   logic signed [15:0] pivot_y;
   logic signed [16:0] sin_value;
   logic signed [16:0] cos_value;
   modport source (output valid, pivot_x, pivot_y, sin_value, cos_value, input ready);
   modport sink   (input valid, pivot_x, pivot_y, sin_value, cos_value, output ready);
endinterface

interface hsvg_rsp_if;
   logic               valid;
   logic               ready;
   logic               is_circle;
   logic [1:0]         shape_index;
   logic [2:0]         vertex_index;
   logic signed [17:0] point_x;
   logic signed [17:0] point_y;
   logic [10:0]        radius;
   logic               thin_mark;
   logic               last_item;
   modport source (output valid, is_circle, shape_index, vertex_index, point_x, point_y,
                   radius, thin_mark, last_item, input ready);
   modport sink   (input valid, is_circle, shape_index, vertex_index, point_x, point_y,
                   radius, thin_mark, last_item, output ready);
endinterface

interface hsvg_csr_if;
   logic                           valid;
   logic                           ready;
   logic [hsvg_pkg::CSR_IDX_W-1:0] index;
   logic [hsvg_pkg::CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/hand_shape_vertex_generator.sv
// hand shape vertex generator top level: sequencer, multiply, divide and output stages
// depends on hsvg_pkg and the interfaces in hsvg_if
// each primitive passes the stage 1 to 3 registers, then the result register
// throughput: one primitive per cycle, 3 to 10 primitives per item by style;
// set by the step sequencer, which a stalled result channel holds
// the next item is taken in the cycle its predecessor's last primitive issues
// reset: synchronous, clears the pipeline valids and loads the register defaults
module hand_shape_vertex_generator (
   input  logic               clock,
   input  logic               reset,
   hsvg_req_if.sink           req_ch,
   hsvg_rsp_if.source         rsp_ch,
   hsvg_csr_if.sink           csr_ch
);

   // registers
   logic [2:0]        hand_style_ff;
   logic [7:0]        hand_length_ff;
   logic [6:0]        tail_length_ff;
   logic signed [7:0] middle_distance_ff;
   logic [7:0]        main_width_ff;
   logic [7:0]        second_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hand_style_ff      <= hsvg_pkg::STYLE_SQUARE;
         hand_length_ff     <= '0;
         tail_length_ff     <= '0;
         middle_distance_ff <= '0;
         main_width_ff      <= 8'd1;
         second_width_ff    <= 8'd1;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            hsvg_pkg::CSR_HAND_STYLE:      hand_style_ff      <= csr_ch.data[2:0];
            hsvg_pkg::CSR_HAND_LENGTH:     hand_length_ff     <= csr_ch.data;
            hsvg_pkg::CSR_TAIL_LENGTH:     tail_length_ff     <= csr_ch.data[6:0];
            hsvg_pkg::CSR_MIDDLE_DISTANCE: middle_distance_ff <= $signed(csr_ch.data);
            hsvg_pkg::CSR_MAIN_WIDTH:      main_width_ff      <= csr_ch.data;
            hsvg_pkg::CSR_SECOND_WIDTH:    second_width_ff    <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   // derived distances
   logic signed [hsvg_pkg::AW-1:0] dist_l, dist_b, dist_m, dist_mid, dist_back;
   logic signed [hsvg_pkg::AW-1:0] dist_sum, dist_apex, dist_lm;
   logic signed [8:0]              back_px;
   logic [hsvg_pkg::HW-1:0]        half_main, half_second;
   logic                           thin_main, thin_second, apex_ok;

   always_comb begin
      dist_l   = $signed(hsvg_pkg::AW'(hand_length_ff) << hsvg_pkg::FRAC_BITS);
      dist_b   = -$signed(hsvg_pkg::AW'(tail_length_ff) << hsvg_pkg::FRAC_BITS);
      dist_m   = hsvg_pkg::AW'(middle_distance_ff) <<< hsvg_pkg::FRAC_BITS;
      dist_mid = (dist_m > dist_l) ? dist_l : dist_m;
      back_px  = (9'(middle_distance_ff) > $signed({2'b00, tail_length_ff}))
                 ? 9'(middle_distance_ff) : $signed({2'b00, tail_length_ff});
      dist_back = -(hsvg_pkg::AW'(back_px) <<< hsvg_pkg::FRAC_BITS);
      dist_sum  = dist_l + dist_b;
      // halve toward zero
      dist_apex = ((dist_sum + $signed({{(hsvg_pkg::AW-1){1'b0}},
                                        dist_sum[hsvg_pkg::AW-1]})) >>> 1) + dist_m;
      dist_lm   = dist_l + dist_m;
      apex_ok   = dist_apex > dist_l;
      half_main   = (main_width_ff == '0) ? hsvg_pkg::HW'(1 << (hsvg_pkg::FRAC_BITS - 1))
                    : hsvg_pkg::HW'(main_width_ff) << (hsvg_pkg::FRAC_BITS - 1);
      half_second = (second_width_ff == '0) ? hsvg_pkg::HW'(1 << (hsvg_pkg::FRAC_BITS - 1))
                    : hsvg_pkg::HW'(second_width_ff) << (hsvg_pkg::FRAC_BITS - 1);
      thin_main   = main_width_ff < 8'd3;
      thin_second = second_width_ff < 8'd3;
   end

   // sequencer stage
   logic               busy_ff, busy_in;
   logic [3:0]         step_ff, step_in;
   logic signed [15:0] piv_x_ff, piv_y_ff;
   logic signed [16:0] sin_ff, cos_ff;
   logic               advance, accept, issue;
   hsvg_pkg::prim_desc_type desc;

   function automatic hsvg_pkg::prim_desc_type mk(
      input int circ, input int sh, input int vi,
      input hsvg_pkg::axis_sel_type ax, input hsvg_pkg::side_type sd,
      input int hsec, input int tsec, input int lst);
      hsvg_pkg::prim_desc_type d;
      d.is_circle    = 1'(circ);
      d.shape_index  = 2'(sh);
      d.vertex_index = 3'(vi);
      d.axis         = ax;
      d.side         = sd;
      d.half_second  = 1'(hsec);
      d.thin_second  = 1'(tsec);
      d.last         = 1'(lst);
      return d;
   endfunction

   always_comb begin
      desc = mk(0, 0, 0, hsvg_pkg::AX_B, hsvg_pkg::SD_NONE, 0, 0, 1);
      unique case (hand_style_ff)
         hsvg_pkg::STYLE_TRIANGLE: begin
            unique case (step_ff)
               4'd0: desc = mk(0, 0, 0, hsvg_pkg::AX_B, hsvg_pkg::SD_NEG,  0, 0, 0);
               4'd1: desc = mk(0, 0, 1, hsvg_pkg::AX_B, hsvg_pkg::SD_POS,  0, 0, 0);
               default: desc = mk(0, 0, 2, hsvg_pkg::AX_L, hsvg_pkg::SD_NONE, 0, 0, 1);
            endcase
         end
         hsvg_pkg::STYLE_DAUPHINE: begin
            unique case (step_ff)
               4'd0: desc = mk(0, 0, 0, hsvg_pkg::AX_BACK, hsvg_pkg::SD_NONE, 0, 0, 0);
               4'd1: desc = mk(0, 0, 1, hsvg_pkg::AX_M,    hsvg_pkg::SD_NEG,  0, 0, 0);
               4'd2: desc = mk(0, 0, 2, hsvg_pkg::AX_L,    hsvg_pkg::SD_NONE, 0, 0, 0);
               default: desc = mk(0, 0, 3, hsvg_pkg::AX_M, hsvg_pkg::SD_POS,  0, 0, 1);
            endcase
         end
         hsvg_pkg::STYLE_SWORD: begin
            unique case (step_ff)
               4'd0: desc = mk(0, 0, 0, hsvg_pkg::AX_B,   hsvg_pkg::SD_NEG,  0, 0, 0);
               4'd1: desc = mk(0, 0, 1, hsvg_pkg::AX_MID, hsvg_pkg::SD_NEG,  1, 0, 0);
               4'd2: desc = mk(0, 0, 2, hsvg_pkg::AX_L,   hsvg_pkg::SD_NONE, 0, 0, 0);
               4'd3: desc = mk(0, 0, 3, hsvg_pkg::AX_MID, hsvg_pkg::SD_POS,  1, 0, 0);
               default: desc = mk(0, 0, 4, hsvg_pkg::AX_B, hsvg_pkg::SD_POS, 0, 0, 1);
            endcase
         end
         hsvg_pkg::STYLE_POMME: begin
            unique case (step_ff)
               4'd0: desc = mk(0, 0, 0, hsvg_pkg::AX_M, hsvg_pkg::SD_NEG,  0, 0, 0);
               4'd1: desc = mk(0, 0, 1, hsvg_pkg::AX_M, hsvg_pkg::SD_POS,  0, 0, 0);
               4'd2: desc = mk(0, 0, 2, hsvg_pkg::AX_L, hsvg_pkg::SD_POS,  0, 0, 0);
               4'd3: desc = mk(0, 0, 3, hsvg_pkg::AX_L, hsvg_pkg::SD_NEG,  0, 0, 0);
               4'd4: desc = mk(0, 1, 0, hsvg_pkg::AX_B, hsvg_pkg::SD_NEG,  1, 1, 0);
               4'd5: desc = mk(0, 1, 1, hsvg_pkg::AX_B, hsvg_pkg::SD_POS,  1, 1, 0);
               4'd6: desc = mk(0, 1, 2, hsvg_pkg::AX_M, hsvg_pkg::SD_POS,  1, 1, 0);
               4'd7: desc = mk(0, 1, 3, hsvg_pkg::AX_M, hsvg_pkg::SD_NEG,  1, 1, 0);
               4'd8: desc = mk(1, 0, 0, hsvg_pkg::AX_M, hsvg_pkg::SD_NONE, 0, 0, 0);
               default: desc = mk(1, 1, 0, hsvg_pkg::AX_L, hsvg_pkg::SD_NONE, 0, 0, 1);
            endcase
         end
         hsvg_pkg::STYLE_SPADE: begin
            unique case (step_ff)
               4'd0: desc = mk(0, 0, 0, hsvg_pkg::AX_B,    hsvg_pkg::SD_NEG,  0, 0, 0);
               4'd1: desc = mk(0, 0, 1, hsvg_pkg::AX_B,    hsvg_pkg::SD_POS,  0, 0, 0);
               4'd2: desc = mk(0, 0, 2, hsvg_pkg::AX_L,    hsvg_pkg::SD_POS,  0, 0, 0);
               4'd3: desc = mk(0, 0, 3, hsvg_pkg::AX_L,    hsvg_pkg::SD_NEG,  0, 0, 0);
               4'd4: desc = mk(0, 1, 0, hsvg_pkg::AX_L,    hsvg_pkg::SD_NEG,  1, 1, 0);
               4'd5: desc = mk(0, 1, 1, hsvg_pkg::AX_L,    hsvg_pkg::SD_POS,  1, 1, 0);
               4'd6: desc = mk(0, 1, 2, hsvg_pkg::AX_APEX, hsvg_pkg::SD_NONE, 1, 1, 0);
               4'd7: desc = mk(1, 0, 0, hsvg_pkg::AX_B,    hsvg_pkg::SD_NONE, 0, 0, 0);
               4'd8: desc = mk(1, 1, 0, hsvg_pkg::AX_L,    hsvg_pkg::SD_NONE, 0, 0, 0);
               default: desc = mk(1, 2, 0, hsvg_pkg::AX_L, hsvg_pkg::SD_NONE, 1, 1, 1);
            endcase
         end
         hsvg_pkg::STYLE_ARROW: begin
            unique case (step_ff)
               4'd0: desc = mk(0, 0, 0, hsvg_pkg::AX_B, hsvg_pkg::SD_NEG,  0, 0, 0);
               4'd1: desc = mk(0, 0, 1, hsvg_pkg::AX_B, hsvg_pkg::SD_POS,  0, 0, 0);
               4'd2: desc = mk(0, 0, 2, hsvg_pkg::AX_L, hsvg_pkg::SD_NONE, 0, 0, 0);
               4'd3: desc = mk(0, 1, 0, hsvg_pkg::AX_L, hsvg_pkg::SD_NEG,  1, 1, 0);
               4'd4: desc = mk(0, 1, 1, hsvg_pkg::AX_L, hsvg_pkg::SD_POS,  1, 1, 0);
               default: desc = mk(0, 1, 2, hsvg_pkg::AX_LM, hsvg_pkg::SD_NONE, 1, 1, 1);
            endcase
         end
         default: begin
            // flat capsule, the dot style adds round caps
            unique case (step_ff)
               4'd0: desc = mk(0, 0, 0, hsvg_pkg::AX_B, hsvg_pkg::SD_NEG, 0, 0, 0);
               4'd1: desc = mk(0, 0, 1, hsvg_pkg::AX_B, hsvg_pkg::SD_POS, 0, 0, 0);
               4'd2: desc = mk(0, 0, 2, hsvg_pkg::AX_L, hsvg_pkg::SD_POS, 0, 0, 0);
               4'd3: desc = mk(0, 0, 3, hsvg_pkg::AX_L, hsvg_pkg::SD_NEG, 0, 0,
                               int'(hand_style_ff != hsvg_pkg::STYLE_DOT));
               4'd4: desc = mk(1, 0, 0, hsvg_pkg::AX_B, hsvg_pkg::SD_NONE, 0, 0, 0);
               default: desc = mk(1, 1, 0, hsvg_pkg::AX_L, hsvg_pkg::SD_NONE, 0, 0, 1);
            endcase
         end
      endcase
   end

   logic rsp_valid_ff;
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign issue        = busy_ff && advance;
   assign req_ch.ready = !busy_ff || (advance && desc.last);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (issue) begin
         busy_in = !desc.last;
         // spade without its point skips polygon 1
         if (hand_style_ff == hsvg_pkg::STYLE_SPADE && step_ff == 4'd3 && !apex_ok) begin
            step_in = 4'd7;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
      if (accept) begin
         busy_in = 1'b1;
         step_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         piv_x_ff <= req_ch.pivot_x;
         piv_y_ff <= req_ch.pivot_y;
         sin_ff   <= req_ch.sin_value;
         cos_ff   <= req_ch.cos_value;
      end
   end

   // stage 1: selected distance and half-width
   logic                           s1_valid_ff, s2_valid_ff, s3_valid_ff;
   hsvg_pkg::prim_desc_type        s1_desc_ff, s2_desc_ff, s3_desc_ff;
   logic                           s1_thin_ff, s2_thin_ff, s3_thin_ff;
   logic signed [hsvg_pkg::AW-1:0] s1_axis_in, s1_axis_ff;
   logic [hsvg_pkg::HW-1:0]        s1_half_ff, s2_half_ff, s3_half_ff;
   logic signed [15:0]             s1_px_ff, s1_py_ff, s2_px_ff, s2_py_ff, s3_px_ff, s3_py_ff;
   logic signed [16:0]             s1_sin_ff, s1_cos_ff;

   always_comb begin
      case (desc.axis)
         hsvg_pkg::AX_L:    s1_axis_in = dist_l;
         hsvg_pkg::AX_M:    s1_axis_in = dist_m;
         hsvg_pkg::AX_MID:  s1_axis_in = dist_mid;
         hsvg_pkg::AX_BACK: s1_axis_in = dist_back;
         hsvg_pkg::AX_APEX: s1_axis_in = dist_apex;
         hsvg_pkg::AX_LM:   s1_axis_in = dist_lm;
         default:           s1_axis_in = dist_b;
      endcase
   end

   // stage 2: products, stage 3: quotients
   logic signed [hsvg_pkg::PW-1:0] s2_pas_ff, s2_pac_ff, s2_phc_ff, s2_phs_ff;
   logic signed [hsvg_pkg::QW-1:0] s3_qas_ff, s3_qac_ff, s3_qhc_ff, s3_qhs_ff;
   logic signed [hsvg_pkg::HW:0]   s1_half_s;

   assign s1_half_s = $signed({1'b0, s1_half_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_desc_ff <= desc;
         s1_thin_ff <= desc.thin_second ? thin_second : thin_main;
         s1_axis_ff <= s1_axis_in;
         s1_half_ff <= desc.half_second ? half_second : half_main;
         s1_px_ff   <= piv_x_ff;
         s1_py_ff   <= piv_y_ff;
         s1_sin_ff  <= sin_ff;
         s1_cos_ff  <= cos_ff;

         s2_desc_ff <= s1_desc_ff;
         s2_thin_ff <= s1_thin_ff;
         s2_half_ff <= s1_half_ff;
         s2_px_ff   <= s1_px_ff;
         s2_py_ff   <= s1_py_ff;
         s2_pas_ff  <= hsvg_pkg::PW'(s1_axis_ff * s1_sin_ff);
         s2_pac_ff  <= hsvg_pkg::PW'(s1_axis_ff * s1_cos_ff);
         s2_phc_ff  <= hsvg_pkg::PW'(s1_half_s * s1_cos_ff);
         s2_phs_ff  <= hsvg_pkg::PW'(s1_half_s * s1_sin_ff);

         s3_desc_ff <= s2_desc_ff;
         s3_thin_ff <= s2_thin_ff;
         s3_half_ff <= s2_half_ff;
         s3_px_ff   <= s2_px_ff;
         s3_py_ff   <= s2_py_ff;
         s3_qas_ff  <= hsvg_pkg::div_trig(s2_pas_ff);
         s3_qac_ff  <= hsvg_pkg::div_trig(s2_pac_ff);
         s3_qhc_ff  <= hsvg_pkg::div_trig(s2_phc_ff);
         s3_qhs_ff  <= hsvg_pkg::div_trig(s2_phs_ff);
      end
   end

   // stage 4: point assembly into the result register
   logic signed [18:0] sum_x, sum_y, off_x, off_y;

   always_comb begin
      case (s3_desc_ff.side)
         hsvg_pkg::SD_NEG: begin
            off_x = -19'(s3_qhc_ff);
            off_y = -19'(s3_qhs_ff);
         end
         hsvg_pkg::SD_POS: begin
            off_x = 19'(s3_qhc_ff);
            off_y = 19'(s3_qhs_ff);
         end
         default: begin
            off_x = '0;
            off_y = '0;
         end
      endcase
      sum_x = 19'(s3_px_ff) + 19'(s3_qas_ff) + off_x;
      sum_y = 19'(s3_py_ff) - 19'(s3_qac_ff) + off_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ch.is_circle    <= s3_desc_ff.is_circle;
         rsp_ch.shape_index  <= s3_desc_ff.shape_index;
         rsp_ch.vertex_index <= s3_desc_ff.vertex_index;
         rsp_ch.point_x      <= sum_x[17:0];
         rsp_ch.point_y      <= sum_y[17:0];
         rsp_ch.radius       <= s3_desc_ff.is_circle ? s3_half_ff : '0;
         rsp_ch.thin_mark    <= s3_thin_ff;
         rsp_ch.last_item    <= s3_desc_ff.last;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;

endmodule

FILE: sim/hand_shape_vertex_generator_test.sv
// testbench for hand_shape_vertex_generator: random and directed hand items
// checked against an in-bench predictor of the primitive sequence
// depends on hsvg_pkg, the interfaces in hsvg_if and the block itself
`timescale 1ns / 100ps

module hand_shape_vertex_generator_test;

   typedef struct {
      longint px;
      longint py;
      longint sv;
      longint cv;
   } hand_item_type;

   typedef struct {
      bit        circ;
      bit [1:0]  si;
      bit [2:0]  vi;
      bit [17:0] x;
      bit [17:0] y;
      bit [10:0] r;
      bit        thin;
      bit        last;
   } prim_type;

   logic clock;
   logic reset;

   hsvg_req_if req_bus ();
   hsvg_rsp_if rsp_bus ();
   hsvg_csr_if csr_bus ();

   hand_shape_vertex_generator u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   hand_item_type pending_items[$];
   prim_type      expected_prims[$];
   prim_type      vertex_list[$];
   prim_type      circle_list[$];
   int            error_count = 0;
   bit            calm = 0;

   // register copies
   bit [2:0] cfg_style  = hsvg_pkg::STYLE_SQUARE;
   bit [7:0] cfg_length = 0;
   bit [6:0] cfg_tail   = 0;
   bit [7:0] cfg_middle = 0;
   bit [7:0] cfg_main   = 1;
   bit [7:0] cfg_second = 1;

   longint cur_px, cur_py, cur_sv, cur_cv;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint trig_div(longint p);
      return p / longint'(hsvg_pkg::TRIG_SCALE);
   endfunction

   function automatic void axial(longint a, output longint x, output longint y);
      x = cur_px + trig_div(a * cur_sv);
      y = cur_py - trig_div(a * cur_cv);
   endfunction

   function automatic void offset(longint h, output longint dx, output longint dy);
      dx = trig_div(h * cur_cv);
      dy = trig_div(h * cur_sv);
   endfunction

   function automatic longint half_width(bit [7:0] w);
      longint h;
      h = longint'(w) * (1 << hsvg_pkg::FRAC_BITS) / 2;
      return (h < (1 << (hsvg_pkg::FRAC_BITS - 1))) ? (1 << (hsvg_pkg::FRAC_BITS - 1)) : h;
   endfunction

   function automatic void add_vertex(int si, longint x, longint y, bit thin);
      prim_type p;
      int       n;
      n = 0;
      foreach (vertex_list[k]) if (vertex_list[k].si == si) n++;
      p.circ = 1'b0; p.si = 2'(si); p.vi = 3'(n); p.x = 18'(x); p.y = 18'(y); p.r = '0;
      p.thin = thin; p.last = 1'b0;
      vertex_list.push_back(p);
   endfunction

   function automatic void add_circle(longint x, longint y, longint r, bit thin);
      prim_type p;
      p.circ = 1'b1; p.si = 2'(circle_list.size()); p.vi = '0;
      p.x = 18'(x); p.y = 18'(y); p.r = 11'(r);
      p.thin = thin; p.last = 1'b0;
      circle_list.push_back(p);
   endfunction

   function automatic void capsule(int si, longint ia, longint oa, longint h, bit thin,
                                   bit caps);
      longint ix, iy, ox, oy, dx, dy;
      axial(ia, ix, iy);
      axial(oa, ox, oy);
      offset(h, dx, dy);
      add_vertex(si, ix - dx, iy - dy, thin);
      add_vertex(si, ix + dx, iy + dy, thin);
      add_vertex(si, ox + dx, oy + dy, thin);
      add_vertex(si, ox - dx, oy - dy, thin);
      if (caps) begin
         add_circle(ix, iy, h, thin);
         add_circle(ox, oy, h, thin);
      end
   endfunction

   function automatic void taper(int si, longint ba, longint h, longint tx, longint ty,
                                 bit thin);
      longint bx, by, dx, dy;
      axial(ba, bx, by);
      offset(h, dx, dy);
      add_vertex(si, bx - dx, by - dy, thin);
      add_vertex(si, bx + dx, by + dy, thin);
      add_vertex(si, tx, ty, thin);
   endfunction

   // works out the primitives of one hand and queues them
   function automatic void predict_hand(hand_item_type it);
      longint one, len, back, mid, md, hw, hs, eb, apex;
      longint tx, ty, bx, by, mx, my, ax, ay, dx, dy, ex, ey;
      bit     tw, ts;
      one  = 1 << hsvg_pkg::FRAC_BITS;
      len  = longint'(cfg_length) * one;
      back = -(longint'(cfg_tail) * one);
      md   = longint'($signed(cfg_middle));
      mid  = md * one;
      hw   = half_width(cfg_main);
      hs   = half_width(cfg_second);
      tw   = cfg_main < 3;
      ts   = cfg_second < 3;
      cur_px = it.px; cur_py = it.py; cur_sv = it.sv; cur_cv = it.cv;
      vertex_list.delete();
      circle_list.delete();
      case (cfg_style)
         hsvg_pkg::STYLE_TRIANGLE: begin
            axial(len, tx, ty);
            taper(0, back, hw, tx, ty, tw);
         end
         hsvg_pkg::STYLE_DAUPHINE: begin
            eb = (longint'(cfg_tail) < md) ? md : longint'(cfg_tail);
            axial(-(eb * one), bx, by);
            axial(len, tx, ty);
            axial(mid, mx, my);
            offset(hw, dx, dy);
            add_vertex(0, bx, by, tw);
            add_vertex(0, mx - dx, my - dy, tw);
            add_vertex(0, tx, ty, tw);
            add_vertex(0, mx + dx, my + dy, tw);
         end
         hsvg_pkg::STYLE_SWORD: begin
            axial(len, tx, ty);
            axial(back, bx, by);
            axial((mid > len) ? len : mid, mx, my);
            offset(hw, dx, dy);
            offset(hs, ex, ey);
            add_vertex(0, bx - dx, by - dy, tw);
            add_vertex(0, mx - ex, my - ey, tw);
            add_vertex(0, tx, ty, tw);
            add_vertex(0, mx + ex, my + ey, tw);
            add_vertex(0, bx + dx, by + dy, tw);
         end
         hsvg_pkg::STYLE_POMME: begin
            capsule(0, mid, len, hw, tw, 1'b1);
            capsule(1, back, mid, hs, ts, 1'b0);
         end
         hsvg_pkg::STYLE_SPADE: begin
            capsule(0, back, len, hw, tw, 1'b1);
            axial(len, tx, ty);
            add_circle(tx, ty, hs, ts);
            apex = (len + back) / 2 + mid;
            // ornament triangle only when its apex passes the tip
            if (apex > len) begin
               axial(apex, ax, ay);
               offset(hs, ex, ey);
               add_vertex(1, tx - ex, ty - ey, ts);
               add_vertex(1, tx + ex, ty + ey, ts);
               add_vertex(1, ax, ay, ts);
            end
         end
         hsvg_pkg::STYLE_ARROW: begin
            axial(len, tx, ty);
            taper(0, back, hw, tx, ty, tw);
            axial(len + mid, ax, ay);
            offset(hs, ex, ey);
            add_vertex(1, tx - ex, ty - ey, ts);
            add_vertex(1, tx + ex, ty + ey, ts);
            add_vertex(1, ax, ay, ts);
         end
         default: begin
            capsule(0, back, len, hw, tw, cfg_style == hsvg_pkg::STYLE_DOT);
         end
      endcase
      foreach (circle_list[k]) vertex_list.push_back(circle_list[k]);
      vertex_list[vertex_list.size() - 1].last = 1'b1;
      foreach (vertex_list[k]) expected_prims.push_back(vertex_list[k]);
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // input channel driver
   always @(posedge clock) begin
      hand_item_type it;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            it.px = req_bus.pivot_x;
            it.py = req_bus.pivot_y;
            it.sv = req_bus.sin_value;
            it.cv = req_bus.cos_value;
            predict_hand(it);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
               it = pending_items.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.pivot_x   <= it.px[15:0];
               req_bus.pivot_y   <= it.py[15:0];
               req_bus.sin_value <= it.sv[16:0];
               req_bus.cos_value <= it.cv[16:0];
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result channel monitor
   always @(posedge clock) begin
      prim_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || $urandom_range(99) >= 8;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_prims.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               e = expected_prims.pop_front();
               if (rsp_bus.is_circle !== e.circ || rsp_bus.shape_index !== e.si ||
                   rsp_bus.vertex_index !== e.vi || rsp_bus.point_x !== e.x ||
                   rsp_bus.point_y !== e.y || rsp_bus.radius !== e.r ||
                   rsp_bus.thin_mark !== e.thin || rsp_bus.last_item !== e.last)
                  report_mismatch($sformatf(
                     {"got c%0d s%0d v%0d (%0d,%0d) r%0d t%0d l%0d, ",
                      "want c%0d s%0d v%0d (%0d,%0d) r%0d t%0d l%0d"},
                     rsp_bus.is_circle, rsp_bus.shape_index, rsp_bus.vertex_index,
                     rsp_bus.point_x, rsp_bus.point_y, rsp_bus.radius, rsp_bus.thin_mark,
                     rsp_bus.last_item, e.circ, e.si, e.vi, $signed(e.x), $signed(e.y),
                     e.r, e.thin, e.last));
            end
         end
      end
   end

   task automatic wait_idle();
      while (pending_items.size() > 0 || req_bus.valid || expected_prims.size() > 0)
         @(posedge clock);
      // then a margin after the last expected result has left
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(logic [hsvg_pkg::CSR_IDX_W-1:0] idx, logic [7:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      case (idx)
         hsvg_pkg::CSR_HAND_STYLE:      cfg_style  = value[2:0];
         hsvg_pkg::CSR_HAND_LENGTH:     cfg_length = value;
         hsvg_pkg::CSR_TAIL_LENGTH:     cfg_tail   = value[6:0];
         hsvg_pkg::CSR_MIDDLE_DISTANCE: cfg_middle = value;
         hsvg_pkg::CSR_MAIN_WIDTH:      cfg_main   = value;
         hsvg_pkg::CSR_SECOND_WIDTH:    cfg_second = value;
         default: ;
      endcase
   endtask

   task automatic set_hand(bit [2:0] style, bit [7:0] len, bit [7:0] tail, bit [7:0] md,
                           bit [7:0] w1, bit [7:0] w2);
      wait_idle();
      write_reg(hsvg_pkg::CSR_HAND_STYLE, {5'd0, style});
      write_reg(hsvg_pkg::CSR_HAND_LENGTH, len);
      write_reg(hsvg_pkg::CSR_TAIL_LENGTH, tail);
      write_reg(hsvg_pkg::CSR_MIDDLE_DISTANCE, md);
      write_reg(hsvg_pkg::CSR_MAIN_WIDTH, w1);
      write_reg(hsvg_pkg::CSR_SECOND_WIDTH, w2);
   endtask

   task automatic queue_item(longint px, longint py, longint sv, longint cv);
      hand_item_type it;
      it.px = px; it.py = py; it.sv = sv; it.cv = cv;
      pending_items.push_back(it);
   endtask

   // signed value of the given width, biased toward its extremes, zero and minus one
   function automatic longint pick_signed(int w);
      longint v;
      case ($urandom_range(9))
         0: v = -(longint'(1) << (w - 1));
         1: v = (longint'(1) << (w - 1)) - 1;
         2: v = 0;
         3: v = -1;
         default: begin
            v = longint'({$urandom, $urandom}) & ((longint'(1) << w) - 1);
            if (v >= (longint'(1) << (w - 1))) v -= longint'(1) << w;
         end
      endcase
      return v;
   endfunction

   function automatic bit [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'hff;
         2: return 8'($urandom_range(3));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.pivot_x   = '0;
      req_bus.pivot_y   = '0;
      req_bus.sin_value = '0;
      req_bus.cos_value = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset register values
      queue_item(100, -100, 0, 65535);
      // register indexes past the list are ignored
      wait_idle();
      write_reg(3'd6, 8'h5a);
      write_reg(3'd7, 8'ha5);

      for (int s = 0; s < 8; s++) begin
         case (s)
            hsvg_pkg::STYLE_DAUPHINE: set_hand(3'(s), 255, 0, 8'd127, 255, 0);
            hsvg_pkg::STYLE_SWORD:    set_hand(3'(s), 10, 127, 8'd127, 2, 255);
            hsvg_pkg::STYLE_SPADE:    set_hand(3'(s), 20, 0, 8'd127, 0, 3);
            default:                  set_hand(3'(s), 255, 127, 8'h80, 255, 0);
         endcase
         queue_item(32767, -32768, 65535, -65536);
         queue_item(-32768, 32767, -65536, 65535);
         queue_item(0, 0, 46341, 46341);
      end

      // random phases; a hold-off before each one lets every result drain
      for (int ph = 0; ph < 22; ph++) begin
         set_hand(3'($urandom_range(7)), pick_byte(), pick_byte() & 8'h7f, pick_byte(),
                  pick_byte(), pick_byte());
         calm = (ph >= 8 && ph < 12);
         for (int n = 0; n < 20; n++)
            queue_item(pick_signed(16), pick_signed(16), pick_signed(17), pick_signed(17));
      end

      wait_idle();
      if (expected_prims.size() > 0) report_mismatch("results still expected at the end");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

endmodule
